@@ src/brb_pkg.sv @@
package brb_pkg;

  localparam int CNT_W  = 9;
  localparam int DATA_W = 32;
  localparam int BYTE_W = 8;
  localparam int LANES  = 4;
  localparam int STEP_W = 2;

  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_WRITE8  = 3'd1,
    ACT_WRITE16 = 3'd2,
    ACT_WRITE32 = 3'd3,
    ACT_OVWR8   = 3'd4,
    ACT_READ8   = 3'd5,
    ACT_READ16  = 3'd6,
    ACT_READ32  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Outcome of one item, as combined from the lane decisions
  typedef struct packed {
    logic [2:0]       taken;
    logic             under;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } merge_t;

endpackage

@@ src/brb_lane.sv @@
module brb_lane #(
  parameter int AW   = 8,
  parameter int LANE = 0
) (
  input  logic                     is_read,
  input  logic [AW-1:0]            oldest,
  input  logic [brb_pkg::CNT_W-1:0] count,
  input  logic [brb_pkg::CNT_W-1:0] len,
  output logic                     valid,
  output logic [AW-1:0]            addr
);
  import brb_pkg::*;

  localparam logic [CNT_W:0] LANE_W = (CNT_W+1)'(LANE);

  logic [CNT_W:0] oldest_x;
  logic [CNT_W:0] len_x;
  logic [CNT_W:0] sum;
  logic [CNT_W:0] wrapped;

  // Reads walk from the oldest byte; writes start past the held bytes.
  always_comb begin
    oldest_x = (CNT_W+1)'(oldest);
    len_x    = {1'b0, len};
    if (is_read) begin
      valid = ({1'b0, count} > LANE_W);
      sum   = oldest_x + LANE_W;
    end else begin
      valid = (({1'b0, count} + LANE_W) < len_x);
      sum   = oldest_x + {1'b0, count} + LANE_W;
    end
    // a valid lane never passes twice the length, so one subtract wraps it
    wrapped = (sum >= len_x) ? (sum - len_x) : sum;
    addr    = wrapped[AW-1:0];
  end

endmodule

@@ src/brb_merge.sv @@
module brb_merge #(
  parameter int AW = 8
) (
  input  logic [2:0]                action,
  input  logic [brb_pkg::LANES-1:0] lane_valid,
  input  logic [AW-1:0]             oldest,
  input  logic [brb_pkg::CNT_W-1:0] count,
  input  logic [brb_pkg::CNT_W-1:0] len,
  output brb_pkg::merge_t           res,
  output logic [AW-1:0]             oldest_new
);
  import brb_pkg::*;

  action_t          act;
  logic [LANES-1:0] used;
  logic [LANES-1:0] hit;
  logic [2:0]       got;
  logic             ow_full;
  logic [2:0]       adv;
  logic [CNT_W:0]   sum;
  logic [CNT_W:0]   wrapped;

  always_comb begin
    act = action_t'(action);
    unique case (act)
      ACT_WRITE8, ACT_OVWR8, ACT_READ8: used = 4'b0001;
      ACT_WRITE16, ACT_READ16:          used = 4'b0011;
      ACT_WRITE32, ACT_READ32:          used = 4'b1111;
      default:                          used = 4'b0000;
    endcase
    hit     = lane_valid & used;
    got     = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
    ow_full = (act == ACT_OVWR8) && !lane_valid[0];

    res.taken = 3'd0;
    res.under = 1'b0;
    res.count = count;
    adv       = 3'd0;
    case (act)
      ACT_CLEAR: begin
        res.count = '0;
      end
      ACT_WRITE8, ACT_WRITE16, ACT_WRITE32: begin
        res.taken = got;
        res.count = count + CNT_W'(got);
      end
      ACT_OVWR8: begin
        res.taken = 3'd1;
        if (ow_full) begin
          adv = 3'd1;
        end else begin
          res.count = count + CNT_W'(1);
        end
      end
      default: begin
        res.under = (hit != used);
        res.count = count - CNT_W'(got);
        adv       = got;
      end
    endcase

    sum     = (CNT_W+1)'(oldest) + (CNT_W+1)'(adv);
    wrapped = (sum >= {1'b0, len}) ? (sum - {1'b0, len}) : sum;
    oldest_new = (act == ACT_CLEAR) ? '0 : wrapped[AW-1:0];

    res.full  = (res.count == len);
    res.empty = (res.count == '0);
  end

endmodule

@@ src/byte_ring_buffer.sv @@
// Byte FIFO ring over a run-time length of 1 to min(DEPTH, 256) slots.
// Input channel (in_valid/in_ready): one action plus 32 data bits per
// transfer; actions are clear, write 8/16/32, overwrite 8, read 8/16/32.
// Multi-byte values enter and leave low byte first. Output channel
// (out_valid/out_ready): exactly one result per input transfer, carrying
// read data, bytes taken, underflow, fill level and full/empty flags.
// Configuration: cfg_we with cfg_data sets the length in use and empties
// the ring; write it only while no item is in flight.
// Timing: four lanes work out, in parallel, the slot and the take/drop
// decision of each byte; the single byte-wide memory port then moves one
// byte a cycle. An item is taken in the idle state, moves its bytes in the
// run state (clear skips it), and loads its result in the final step; the
// next input transfer waits until the item is back in the idle state.
// A result waiting in the output register does not stop the next input
// transfer; only a second finished result waits in the final step until
// the receiver takes the first.
// Reset (synchronous, rst_n low): ring empty, length 256 (capped at DEPTH),
// output empty. Store contents are not cleared; only written bytes are read.
module byte_ring_buffer #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_value,
  output logic [2:0]  out_bytes_taken,
  output logic        out_underflow,
  output logic [8:0]  out_fill_level,
  output logic        out_is_full,
  output logic        out_is_empty,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data
);
  import brb_pkg::*;

  localparam int LEN_CAP = (DEPTH < 256) ? DEPTH : 256;
  localparam int AW      = $clog2(LEN_CAP);
  localparam logic [CNT_W-1:0] CAP_L = CNT_W'(LEN_CAP);

  // ring state
  logic [CNT_W-1:0]  len_r;
  logic [AW-1:0]     oldest_r;
  logic [CNT_W-1:0]  count_r;
  logic [BYTE_W-1:0] mem [LEN_CAP];

  // item in flight
  state_t            state_r, state_nxt;
  action_t           action_r;
  logic [DATA_W-1:0] data_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] last_step;
  logic              is_read;
  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_merged;
  logic [BYTE_W-1:0] rd_data_r;
  logic              cap_v_r;
  logic [STEP_W-1:0] cap_lane_r;

  // lanes
  logic [LANES-1:0]  lane_valid;
  logic [AW-1:0]     lane_addr [LANES];
  logic              sel_valid;
  logic [AW-1:0]     sel_addr;
  merge_t            mres;
  logic [AW-1:0]     oldest_new;

  // control
  logic accept;
  logic mem_we;
  logic mem_re;
  logic load_out;
  logic [CNT_W-1:0] cfg_len;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  merge_t            out_res_r;

  assign is_read = (action_r == ACT_READ8) || (action_r == ACT_READ16) ||
                   (action_r == ACT_READ32);

  always_comb begin
    case (action_r)
      ACT_WRITE16, ACT_READ16: last_step = STEP_W'(1);
      ACT_WRITE32, ACT_READ32: last_step = STEP_W'(3);
      default:                 last_step = '0;
    endcase
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    brb_lane #(.AW(AW), .LANE(k)) u_lane (
      .is_read (is_read),
      .oldest  (oldest_r),
      .count   (count_r),
      .len     (len_r),
      .valid   (lane_valid[k]),
      .addr    (lane_addr[k])
    );
  end

  brb_merge #(.AW(AW)) u_merge (
    .action     (action_r),
    .lane_valid (lane_valid),
    .oldest     (oldest_r),
    .count      (count_r),
    .len        (len_r),
    .res        (mres),
    .oldest_new (oldest_new)
  );

  assign sel_valid = lane_valid[step_r];
  assign sel_addr  = lane_addr[step_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (action_t'(in_action) == ACT_CLEAR) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN: begin
        // overwrite on a full ring still stores, at the oldest slot
        mem_we = !is_read &&
                 (sel_valid || (action_r == ACT_OVWR8 && step_r == '0));
        mem_re = is_read && sel_valid;
      end
      ST_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // fold a byte that arrived from the memory into its lane's place
  assign value_merged = cap_v_r
      ? (value_r | (DATA_W'(rd_data_r) << {cap_lane_r, 3'b000}))
      : value_r;

  assign cfg_len = (cfg_data == '0) ? CNT_W'(1) :
                   (cfg_data > CAP_L) ? CAP_L : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= CAP_L;
      oldest_r <= '0;
      count_r  <= '0;
      step_r   <= '0;
      cap_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_v_r <= mem_re;
      if (cfg_we) begin
        // a new length also empties the ring
        len_r    <= cfg_len;
        oldest_r <= '0;
        count_r  <= '0;
      end else if (load_out) begin
        oldest_r <= oldest_new;
        count_r  <= mres.count;
      end
      if (accept) begin
        step_r <= '0;
      end else if (state_r == ST_RUN) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // item payload; hold while in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= action_t'(in_action);
      data_r   <= in_data;
      value_r  <= '0;
    end else begin
      value_r  <= value_merged;
    end
    cap_lane_r <= step_r;
  end

  // byte store, one port, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sel_addr] <= data_r[{step_r, 3'b000} +: BYTE_W] & BYTE_MASK;
    end
    if (mem_re) begin
      rd_data_r <= mem[sel_addr];
    end
  end

  // output register: load on the final step, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= value_merged;
      out_res_r   <= mres;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_bytes_taken = out_res_r.taken;
  assign out_underflow   = out_res_r.under;
  assign out_fill_level  = out_res_r.count;
  assign out_is_full     = out_res_r.full;
  assign out_is_empty    = out_res_r.empty;

endmodule

@@ src/brb_checker.sv @@
module brb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_bytes_taken,
  input logic        out_underflow,
  input logic [8:0]  out_fill_level,
  input logic        out_is_full,
  input logic        out_is_empty
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_fill_level == 9'd0)))
    else $error("empty flag disagrees with fill level");

  a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_full) |-> (out_fill_level != 9'd0))
    else $error("full ring reported with no bytes held");

  a_under_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_underflow) |-> (out_bytes_taken == 3'd0))
    else $error("underflow on an item that stored bytes");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_bytes_taken (out_bytes_taken),
  .out_underflow   (out_underflow),
  .out_fill_level  (out_fill_level),
  .out_is_full     (out_is_full),
  .out_is_empty    (out_is_empty)
);

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  // Allow this many cycles with no transfer on either channel before giving up
  localparam int IDLE_LIMIT    = 1000;
  // Hold off a little longer than the longest item (read32) needs before a
  // register write and at the end of the run
  localparam int SETTLE_CYCLES = 10;
  localparam int RING_CAP      = 256;

  // Receiver behaviour, chosen afresh for each stretch of cycles
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_BURSTY
  } rx_mode_t;

  // What the ring should report for one item
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  taken;
    logic        under;
    logic [8:0]  level;
    logic        full;
    logic        empty;
  } ring_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = ACT_CLEAR;
  logic [31:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_value;
  logic [2:0]  out_bytes_taken;
  logic        out_underflow;
  logic [8:0]  out_fill_level;
  logic        out_is_full;
  logic        out_is_empty;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_data = '0;

  byte_ring_buffer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_bytes_taken (out_bytes_taken),
    .out_underflow   (out_underflow),
    .out_fill_level  (out_fill_level),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  // 20 ns period: rising edges at 10, 30, ...
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted ring: its own byte store, head, fill and length register
  // ---------------------------------------------------------------------------
  logic [7:0]    ring_bytes [RING_CAP];
  int            ring_head = 0;
  int            ring_fill = 0;
  logic [8:0]    ring_len_reg = 9'd256;
  ring_outcome_t queued_outcomes [$];

  // Run statistics for the closing summary
  int mismatches     = 0;
  int items_taken    = 0;
  int results_seen   = 0;
  int short_reads    = 0;
  int partial_writes = 0;
  int full_results   = 0;
  int lengths_set    = 0;
  int idle_cycles    = 0;

  // Slots the ring actually wraps over: zero acts as one, anything past the
  // store size is clamped to it
  function automatic int slots_in_use();
    int v;
    v = ring_len_reg;
    if (v == 0) v = 1;
    if (v > RING_CAP) v = RING_CAP;
    return v;
  endfunction

  // Apply one action to the predicted ring and return what the block should report
  function automatic ring_outcome_t advance_ring(action_t act, logic [31:0] data);
    ring_outcome_t r;
    int            len;
    int            nbytes;
    r = '0;
    len = slots_in_use();
    case (act)
      ACT_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
      end
      ACT_WRITE8, ACT_WRITE16, ACT_WRITE32: begin
        nbytes = (act == ACT_WRITE8) ? 1 : (act == ACT_WRITE16) ? 2 : 4;
        // Drop each byte that finds the ring full; later bytes are dropped too
        for (int i = 0; i < nbytes; i++) begin
          if (ring_fill < len) begin
            ring_bytes[8'((ring_head + ring_fill) % len)] = data[8*i +: 8];
            ring_fill++;
            r.taken++;
          end
        end
      end
      ACT_OVWR8: begin
        // Always store; on a full ring replace the oldest byte and advance past it
        if (ring_fill < len) begin
          ring_bytes[8'((ring_head + ring_fill) % len)] = data[7:0];
          ring_fill++;
        end else begin
          ring_bytes[8'(ring_head)] = data[7:0];
          ring_head = (ring_head + 1) % len;
        end
        r.taken = 3'd1;
      end
      default: begin
        nbytes = (act == ACT_READ8) ? 1 : (act == ACT_READ16) ? 2 : 4;
        // A byte that finds the ring empty reads as zero and flags underflow
        for (int i = 0; i < nbytes; i++) begin
          if (ring_fill == 0) begin
            r.under = 1'b1;
          end else begin
            r.value[8*i +: 8] = ring_bytes[8'(ring_head)];
            ring_head = (ring_head + 1) % len;
            ring_fill--;
          end
        end
      end
    endcase
    r.level = ring_fill[8:0];
    r.full  = (ring_fill == len);
    r.empty = (ring_fill == 0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction, then
  // predict for any input transfer and track register writes. Results never
  // leave on the edge that takes their own item, so the order here is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ring_outcome_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (queued_outcomes.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          w = queued_outcomes.pop_front();
          compare_field("read_value", w.value, out_read_value);
          compare_field("bytes_taken", 32'(w.taken), 32'(out_bytes_taken));
          compare_field("underflow", 32'(w.under), 32'(out_underflow));
          compare_field("fill_level", 32'(w.level), 32'(out_fill_level));
          compare_field("is_full", 32'(w.full), 32'(out_is_full));
          compare_field("is_empty", 32'(w.empty), 32'(out_is_empty));
        end
      end
      if (in_valid && in_ready) begin
        w = advance_ring(action_t'(in_action), in_data);
        queued_outcomes.push_back(w);
        items_taken++;
        if (w.under) short_reads++;
        if (w.taken != 0 && w.taken < 3'd4 && in_action == ACT_WRITE32) partial_writes++;
        if (w.taken == 3'd1 && in_action == ACT_WRITE16) partial_writes++;
        if (w.full) full_results++;
      end
      // Writing the length register also empties the ring
      if (cfg_we) begin
        ring_len_reg = cfg_data;
        ring_head = 0;
        ring_fill = 0;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                   IDLE_LIMIT, queued_outcomes.size());
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, switching mode every so often
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  int unsigned rx_stall = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
      default: begin
        // Mostly ready, with occasional stalls
        if (rx_stall != 0) begin
          rx_stall--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 15);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. Every task here
  // starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_item(action_t act, logic [31:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      // A quarter of the bursts follow straight on, with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    // Hold valid and payload until the transfer; valid stays high if the
    // next call follows at once
    in_valid  = 1'b1;
    in_action = act;
    in_data   = data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and hold off until every outstanding result has come back
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (queued_outcomes.size() != 0) @(negedge clk);
  endtask

  // Write the length register only with the ring idle
  task automatic set_ring_length(logic [8:0] code);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = code;
    @(negedge clk);
    cfg_we   = 1'b0;
    lengths_set++;
  endtask

  // Mostly writes when write_pct is high, mostly reads when low; clear is rare
  function automatic action_t pick_action(int write_pct);
    int roll;
    int pick;
    roll = $urandom_range(0, 99);
    if (roll < 2) return ACT_CLEAR;
    if (roll < 2 + (write_pct * 98) / 100) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) return ACT_WRITE8;
      if (pick < 8) return ACT_WRITE16;
      if (pick < 17) return ACT_WRITE32;
      return ACT_OVWR8;
    end
    pick = $urandom_range(0, 2);
    return (pick == 0) ? ACT_READ8 : (pick == 1) ? ACT_READ16 : ACT_READ32;
  endfunction

  // One length setting: fill-biased first half, then pause for every result,
  // then drain-biased second half
  task automatic run_phase(logic [8:0] code, int items, int write_pct);
    int wp;
    wp = write_pct;
    set_ring_length(code);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) begin
        wait_for_results();
        wp = 100 - write_pct;
      end
      send_item(pick_action(wp), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reads straight after reset find nothing: zeros and underflow
  task automatic test_empty_reads();
    send_item(ACT_READ8, 32'hFFFF_FFFF);
    send_item(ACT_READ32, 32'h0000_0000);
  endtask

  // Low byte in first and out first; short reads pad with zeros
  task automatic test_byte_order();
    send_item(ACT_WRITE32, 32'h0403_0201);
    send_item(ACT_READ16, 32'hFFFF_FFFF);
    send_item(ACT_READ32, 32'h0000_0000);
    send_item(ACT_WRITE8, 32'hFFFF_FFFF);
    send_item(ACT_WRITE16, 32'h0000_FFFF);
    send_item(ACT_READ32, 32'h0000_0000);
    send_item(ACT_WRITE32, 32'h0000_0000);
    send_item(ACT_CLEAR, 32'hFFFF_FFFF);
    send_item(ACT_READ8, 32'h0000_0000);
  endtask

  // Tiny rings: partly taken writes, dropped bytes, overwrite at full,
  // and a zero length acting as one slot
  task automatic test_tiny_ring();
    set_ring_length(9'd2);
    send_item(ACT_WRITE32, 32'hA1B2_C3D4);
    send_item(ACT_WRITE8, 32'h0000_0055);
    send_item(ACT_OVWR8, 32'h0000_005A);
    send_item(ACT_READ16, 32'h0000_0000);
    set_ring_length(9'd0);
    send_item(ACT_WRITE16, 32'h0000_1234);
    send_item(ACT_OVWR8, 32'hFFFF_FFEE);
    send_item(ACT_READ8, 32'h0000_0000);
    send_item(ACT_READ8, 32'h0000_0000);
  endtask

  // Length codes above the store size clamp to it
  task automatic test_length_clamp();
    set_ring_length(9'd511);
    send_item(ACT_WRITE32, 32'hFFFF_FFFF);
    send_item(ACT_READ8, 32'h0000_0000);
    set_ring_length(9'd257);
    send_item(ACT_WRITE16, 32'h0000_8001);
    send_item(ACT_OVWR8, 32'h0000_007F);
    send_item(ACT_READ32, 32'h0000_0000);
    set_ring_length(9'd1);
    send_item(ACT_WRITE8, 32'h0000_0000);
  endtask

  // Large rings filled to the brim, overwritten and wrapped, then drained
  task automatic test_full_ring();
    run_phase(9'd256, 260, 95);
    run_phase(9'd511, 200, 95);
    run_phase(9'd255, 200, 97);
  endtask

  // Small rings where full, empty and wrap come round constantly
  task automatic test_small_rings();
    run_phase(9'd1, 60, 50);
    run_phase(9'd0, 50, 50);
    run_phase(9'd2, 70, 60);
    run_phase(9'd3, 70, 55);
    run_phase(9'd5, 70, 60);
    run_phase(9'd7, 70, 50);
  endtask

  // Middling and random lengths
  task automatic test_mixed_lengths();
    run_phase(9'd16, 90, 65);
    run_phase(9'd257, 60, 70);
    run_phase(9'd100, 120, 75);
    run_phase(9'($urandom_range(0, 511)), 60, 70);
    run_phase(9'($urandom_range(0, 511)), 60, 70);
  endtask

  initial begin
    // Reset once, released at a falling edge
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_empty_reads();
    test_byte_order();
    test_tiny_ring();
    test_length_clamp();
    test_full_ring();
    test_small_rings();
    test_mixed_lengths();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d item transfers and %0d results over %0d length settings.",
             items_taken, results_seen, lengths_set);
    $display("Seen %0d short reads, %0d partly taken writes, %0d results at full ring.",
             short_reads, partial_writes, full_results);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
